// ----- hw/rtl/b2r_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_pkg
// Shared types, letter codes and spelling helpers for the Roman numeral core.
// ----------------------------------------------------------------------------
package b2r_pkg;

  localparam int unsigned ValueW     = 12;
  localparam int unsigned SymbolW    = 7;
  localparam int unsigned MidDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  // decimal places, index into bcd_t
  localparam logic [1:0] PlaceUnit = 2'd0;
  localparam logic [1:0] PlaceTens = 2'd1;
  localparam logic [1:0] PlaceHund = 2'd2;
  localparam logic [1:0] PlaceThou = 2'd3;

  localparam logic [SymbolW-1:0] CharI = 7'h49;
  localparam logic [SymbolW-1:0] CharV = 7'h56;
  localparam logic [SymbolW-1:0] CharX = 7'h58;
  localparam logic [SymbolW-1:0] CharL = 7'h4C;
  localparam logic [SymbolW-1:0] CharC = 7'h43;
  localparam logic [SymbolW-1:0] CharD = 7'h44;
  localparam logic [SymbolW-1:0] CharM = 7'h4D;
  localparam logic [SymbolW-1:0] CharNone = 7'h00;

  typedef logic [3:0]       digit_t;
  typedef digit_t [3:0]     bcd_t;   // [3] thousands .. [0] units

  typedef struct packed {
    logic [SymbolW-1:0] symbol;
    logic               last;
    logic               empty_res;
  } res_t;

  function automatic logic [SymbolW-1:0] one_letter(input logic [1:0] p);
    logic [SymbolW-1:0] c;
    case (p)
      PlaceUnit: c = CharI;
      PlaceTens: c = CharX;
      PlaceHund: c = CharC;
      default:   c = CharM;
    endcase
    return c;
  endfunction

  function automatic logic [SymbolW-1:0] five_letter(input logic [1:0] p);
    logic [SymbolW-1:0] c;
    case (p)
      PlaceUnit: c = CharV;
      PlaceTens: c = CharL;
      PlaceHund: c = CharD;
      default:   c = CharM;
    endcase
    return c;
  endfunction

  function automatic logic [SymbolW-1:0] ten_letter(input logic [1:0] p);
    logic [SymbolW-1:0] c;
    case (p)
      PlaceUnit: c = CharX;
      PlaceTens: c = CharC;
      default:   c = CharM;
    endcase
    return c;
  endfunction

  // number of letters a digit spells at a place
  function automatic logic [2:0] digit_len(input digit_t d, input logic [1:0] p);
    logic [2:0] n;
    if (p == PlaceThou) begin
      n = d[2:0];
    end else begin
      case (d)
        4'd1:    n = 3'd1;
        4'd2:    n = 3'd2;
        4'd3:    n = 3'd3;
        4'd4:    n = 3'd2;
        4'd5:    n = 3'd1;
        4'd6:    n = 3'd2;
        4'd7:    n = 3'd3;
        4'd8:    n = 3'd4;
        4'd9:    n = 3'd2;
        default: n = 3'd0;
      endcase
    end
    return n;
  endfunction

  // k-th letter of a digit at a place
  function automatic logic [SymbolW-1:0] digit_letter(input digit_t d, input logic [1:0] p,
                                                      input logic [1:0] k);
    logic [SymbolW-1:0] c;
    if (p == PlaceThou) begin
      c = CharM;
    end else if (d == 4'd4) begin
      c = (k == 2'd0) ? one_letter(p) : five_letter(p);
    end else if (d == 4'd9) begin
      c = (k == 2'd0) ? one_letter(p) : ten_letter(p);
    end else if (d >= 4'd5) begin
      c = (k == 2'd0) ? five_letter(p) : one_letter(p);
    end else begin
      c = one_letter(p);
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/binary_to_roman_numeral_core.sv -----
`timescale 1ns / 1ps
// Path: a value passes the 12 BCD conversion steps, the digit queue and the
//   back-end load before its first letter reaches the result side.
// Rate: one letter per cycle while the result queue is not full; a new value
//   is taken only once the 12-step converter has pushed the last one.
// Reset: asynchronous active-low rst_ni clears both queues and all control.
// ----------------------------------------------------------------------------
// binary_to_roman_numeral_core
// Converts a 12-bit value into its Roman numeral, one ASCII letter per
// result transaction, with the final letter marked; zero gives one empty item.
// ----------------------------------------------------------------------------
module binary_to_roman_numeral_core #(
  parameter int unsigned MidDepth = b2r_pkg::MidDepthDef,
  parameter int unsigned OutDepth = b2r_pkg::OutDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push,
  output logic                         full,
  input  logic [b2r_pkg::ValueW-1:0]   value_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [b2r_pkg::SymbolW-1:0]  symbol_o,
  output logic                         last_o,
  output logic                         empty_res_o
);
  import b2r_pkg::*;

  logic  fr_push, mid_full, mid_empty, mid_pop;
  bcd_t  fr_bcd, mid_bcd;
  logic  out_wr, out_full;
  res_t  out_item, out_head;

  b2r_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (push),
    .value_i (value_i),
    .busy_o  (full),
    .push_o  (fr_push),
    .bcd_o   (fr_bcd),
    .full_i  (mid_full)
  );

  b2r_fifo #(
    .Width ($bits(bcd_t)),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_push),
    .wr_data_i (fr_bcd),
    .full_o    (mid_full),
    .rd_i      (mid_pop),
    .rd_data_o (mid_bcd),
    .empty_o   (mid_empty)
  );

  b2r_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (mid_empty),
    .bcd_i   (mid_bcd),
    .pop_o   (mid_pop),
    .wr_o    (out_wr),
    .res_o   (out_item),
    .full_i  (out_full)
  );

  b2r_fifo #(
    .Width ($bits(res_t)),
    .Depth (OutDepth)
  ) u_out_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (out_wr),
    .wr_data_i (out_item),
    .full_o    (out_full),
    .rd_i      (pop),
    .rd_data_o (out_head),
    .empty_o   (empty)
  );

  assign symbol_o    = out_head.symbol;
  assign last_o      = out_head.last;
  assign empty_res_o = out_head.empty_res;

  a_zero_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_res_o) |-> (last_o && symbol_o == CharNone))
    else $error("zero-value transaction not marked last with null symbol");

  a_letter_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !empty_res_o) |-> (symbol_o == CharI || symbol_o == CharV ||
      symbol_o == CharX || symbol_o == CharL || symbol_o == CharC ||
      symbol_o == CharD || symbol_o == CharM))
    else $error("result symbol is not a Roman letter");

  a_mid_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop |-> !mid_empty)
    else $error("back end popped an empty digit queue");

  a_out_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_wr |-> !out_full)
    else $error("back end wrote a full result queue");

endmodule

// ----- hw/rtl/b2r_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_fifo
// Small register queue with push/full and pop/empty sides (depth >= 2).
// ----------------------------------------------------------------------------
module b2r_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

// ----- hw/rtl/b2r_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_front
// Accepts a value and splits it into four BCD digits, one shift-add3 step
// per cycle, then hands the digits to the digit queue.
// ----------------------------------------------------------------------------
module b2r_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [b2r_pkg::ValueW-1:0]   value_i,
  output logic                         busy_o,
  output logic                         push_o,
  output b2r_pkg::bcd_t                bcd_o,
  input  logic                         full_i
);
  import b2r_pkg::*;

  typedef enum logic [1:0] {
    FrIdle,
    FrConv,
    FrPush
  } fr_state_e;

  localparam int unsigned StepW = $clog2(ValueW);

  fr_state_e          state_q;
  logic [StepW-1:0]   step_q;
  logic [ValueW-1:0]  bin_q;
  bcd_t               bcd_q;
  bcd_t               adj;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
  end

  assign busy_o = (state_q != FrIdle);
  assign push_o = (state_q == FrPush);
  assign bcd_o  = bcd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      step_q  <= '0;
    end else begin
      case (state_q)
        FrIdle: begin
          if (valid_i) begin
            state_q <= FrConv;
            step_q  <= '0;
          end
        end
        FrConv: begin
          step_q <= step_q + 1'b1;
          if (step_q == StepW'(ValueW - 1)) begin
            state_q <= FrPush;
          end
        end
        FrPush: begin
          if (!full_i) begin
            state_q <= FrIdle;
          end
        end
        default: state_q <= FrIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FrIdle && valid_i) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (state_q == FrConv) begin
      {bcd_q, bin_q} <= {adj[3][2:0], adj[2], adj[1], adj[0], bin_q, 1'b0};
    end
  end

endmodule

// ----- hw/rtl/b2r_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2r_back
// Takes digit sets from the digit queue and spells them one letter per
// cycle into the result queue while it has room, skipping zero digits.
// ----------------------------------------------------------------------------
module b2r_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  b2r_pkg::bcd_t  bcd_i,
  output logic           pop_o,
  output logic           wr_o,
  output b2r_pkg::res_t  res_o,
  input  logic           full_i
);
  import b2r_pkg::*;

  logic       active_q, active_d;
  bcd_t       dig_q;
  logic [1:0] pos_q, pos_d;
  logic [1:0] k_q, k_d;

  logic [3:0] nz_cur, nz_new;
  logic [1:0] next_pos, first_pos;
  logic       found_next, found_first;
  digit_t     cur_digit;
  logic [2:0] cur_len;
  logic       digit_done;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      nz_cur[i] = (dig_q[i] != '0);
      nz_new[i] = (bcd_i[i] != '0);
    end
  end

  // next nonzero place below the current one
  always_comb begin
    next_pos   = PlaceUnit;
    found_next = 1'b0;
    for (int i = 2; i >= 0; i--) begin
      if (!found_next && (i < pos_q) && nz_cur[i]) begin
        next_pos   = 2'(i);
        found_next = 1'b1;
      end
    end
  end

  // leading nonzero place of a new digit set
  always_comb begin
    first_pos   = PlaceUnit;
    found_first = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      if (!found_first && nz_new[i]) begin
        first_pos   = 2'(i);
        found_first = 1'b1;
      end
    end
  end

  assign cur_digit  = dig_q[pos_q];
  assign cur_len    = digit_len(cur_digit, pos_q);
  assign digit_done = ({1'b0, k_q} + 3'd1) == cur_len;

  always_comb begin
    active_d        = active_q;
    pos_d           = pos_q;
    k_d             = k_q;
    pop_o           = 1'b0;
    wr_o            = 1'b0;
    res_o.symbol    = digit_letter(cur_digit, pos_q, k_q);
    res_o.last      = digit_done && !found_next;
    res_o.empty_res = 1'b0;
    if (!active_q) begin
      if (!empty_i && !full_i) begin
        pop_o = 1'b1;
        if (!found_first) begin
          // zero value: a single flagged transaction
          wr_o            = 1'b1;
          res_o.symbol    = CharNone;
          res_o.last      = 1'b1;
          res_o.empty_res = 1'b1;
        end else begin
          active_d = 1'b1;
          pos_d    = first_pos;
          k_d      = '0;
        end
      end
    end else if (!full_i) begin
      wr_o = 1'b1;
      if (digit_done) begin
        k_d = '0;
        if (found_next) begin
          pos_d = next_pos;
        end else begin
          active_d = 1'b0;
        end
      end else begin
        k_d = k_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pos_q    <= '0;
      k_q      <= '0;
    end else begin
      active_q <= active_d;
      pos_q    <= pos_d;
      k_q      <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      dig_q <= bcd_i;
    end
  end

endmodule

// ----- sim/roman_letter_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roman_letter_checker
// Watches both queue ports of the Roman numeral core, spells every accepted
// value into its expected letters and compares each popped letter in order.
// ----------------------------------------------------------------------------
module roman_letter_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic                        full_i,
  input  logic [b2r_pkg::ValueW-1:0]  value_i,
  input  logic                        empty_i,
  input  logic                        pop_i,
  input  logic [b2r_pkg::SymbolW-1:0] symbol_i,
  input  logic                        last_i,
  input  logic                        empty_res_i,
  output int unsigned                 mismatches_o,
  output int unsigned                 letters_due_o
);
  import b2r_pkg::*;

  res_t letters_due_q[$];

  // Spell one value into the queue of letters still to come.
  function automatic void spell_value(input logic [ValueW-1:0] v);
    logic [SymbolW-1:0] word[$];
    logic [SymbolW-1:0] one_l[3];
    logic [SymbolW-1:0] five_l[3];
    logic [SymbolW-1:0] ten_l[3];
    int unsigned        digit[3];
    int unsigned        thou;
    int unsigned        d;
    res_t               r;

    if (v == '0) begin
      r.symbol    = CharNone;
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      letters_due_q.push_back(r);
      return;
    end
    one_l[0] = CharC;  five_l[0] = CharD;  ten_l[0] = CharM;
    one_l[1] = CharX;  five_l[1] = CharL;  ten_l[1] = CharC;
    one_l[2] = CharI;  five_l[2] = CharV;  ten_l[2] = CharX;
    thou     = v / 1000;
    digit[0] = (v % 1000) / 100;
    digit[1] = (v % 100) / 10;
    digit[2] = v % 10;

    for (int i = 0; i < int'(thou); i++) word.push_back(CharM);
    for (int p = 0; p < 3; p++) begin
      d = digit[p];
      if (d == 4) begin
        word.push_back(one_l[p]);
        word.push_back(five_l[p]);
      end else if (d == 9) begin
        word.push_back(one_l[p]);
        word.push_back(ten_l[p]);
      end else begin
        if (d >= 5) word.push_back(five_l[p]);
        for (int k = 0; k < int'(d % 5); k++) word.push_back(one_l[p]);
      end
    end
    foreach (word[i]) begin
      r.symbol    = word[i];
      r.last      = (i == word.size() - 1);
      r.empty_res = 1'b0;
      letters_due_q.push_back(r);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      letters_due_q.delete();
      mismatches_o  <= 0;
      letters_due_o <= 0;
    end else begin
      // compare before predicting: a letter can never leave in the cycle
      // its value enters
      if (pop_i && !empty_i) begin
        got.symbol    = symbol_i;
        got.last      = last_i;
        got.empty_res = empty_res_i;
        if (letters_due_q.size() == 0) begin
          if (mismatches_o < 10)
            $display("%0t: unexpected letter sym=%h last=%b empty=%b",
                     $realtime, got.symbol, got.last, got.empty_res);
          mismatches_o <= mismatches_o + 1;
        end else begin
          want = letters_due_q.pop_front();
          if (got !== want) begin
            if (mismatches_o < 10)
              $display("%0t: letter mismatch exp sym=%h last=%b empty=%b,",
                       $realtime, want.symbol, want.last, want.empty_res,
                       " got sym=%h last=%b empty=%b",
                       got.symbol, got.last, got.empty_res);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (push_i && !full_i) spell_value(value_i);
      letters_due_o <= letters_due_q.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives values into the Roman numeral core with random push gaps and pop
// stalls; a checker beside the core predicts and compares every letter.
// ----------------------------------------------------------------------------
module tb;
  import b2r_pkg::*;

  logic               clk_i      = 1'b0;
  logic               rst_ni     = 1'b0;
  logic               push       = 1'b0;
  logic               pop        = 1'b0;
  logic [ValueW-1:0]  value      = '0;
  logic               full;
  logic               empty;
  logic [SymbolW-1:0] symbol;
  logic               last_flag;
  logic               zero_flag;
  logic               burst_mode = 1'b0;
  int unsigned        mismatches;
  int unsigned        letters_due;
  int unsigned        pop_hold   = 0;
  int unsigned        pop_roll;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  binary_to_roman_numeral_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .value_i     (value),
    .empty       (empty),
    .pop         (pop),
    .symbol_o    (symbol),
    .last_o      (last_flag),
    .empty_res_o (zero_flag)
  );

  roman_letter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_i        (full),
    .value_i       (value),
    .empty_i       (empty),
    .pop_i         (pop),
    .symbol_i      (symbol),
    .last_i        (last_flag),
    .empty_res_i   (zero_flag),
    .mismatches_o  (mismatches),
    .letters_due_o (letters_due)
  );

  // receiver: mostly ready, short stalls, now and then a long one
  always @(posedge clk_i) begin
    pop_roll = $urandom_range(0, 99);
    if (pop_hold > 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (burst_mode) begin
      pop <= 1'b1;
    end else if (pop_roll < 6) begin
      pop      <= 1'b0;
      pop_hold <= $urandom_range(8, 40);
    end else begin
      pop <= (pop_roll >= 35);
    end
  end

  function automatic int unsigned push_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // one transaction; push stays high afterwards unless a gap follows
  task automatic send_value(input logic [ValueW-1:0] v);
    int unsigned gap;
    push  <= 1'b1;
    value <= v;
    do @(posedge clk_i); while (full);
    gap = push_gap();
    if (gap > 0) begin
      push  <= 1'b0;
      value <= ValueW'($urandom());
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (letters_due != 0);
  endtask

  initial begin
    logic [ValueW-1:0] directed[$];
    int unsigned       roll;

    directed = {12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd3888, 12'd3999, 12'd4000,
                12'd4095, 12'd4088, 12'd2730, 12'd1365, 12'd2048, 12'd1000,
                12'd444, 12'd999, 12'd40, 12'd90, 12'd400, 12'd900, 12'd8,
                12'd3, 12'd0, 12'd1994};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_value(directed[i]);
    wait_drained();

    for (int n = 0; n < 136; n++) begin
      if (n == 60) burst_mode <= 1'b1;
      if (n == 100) begin
        burst_mode <= 1'b0;
        wait_drained();
      end
      roll = $urandom_range(0, 99);
      if (roll < 5)       send_value('0);
      else if (roll < 13) send_value(ValueW'($urandom_range(4000, 4095)));
      else if (roll < 20) send_value(ValueW'($urandom()));
      else                send_value(ValueW'($urandom_range(1, 3999)));
    end

    wait_drained();
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && letters_due == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/b2r_pkg.sv
hw/rtl/b2r_fifo.sv
hw/rtl/b2r_front.sv
hw/rtl/b2r_back.sv
hw/rtl/binary_to_roman_numeral_core.sv
sim/roman_letter_checker.sv
sim/tb.sv
